// File: hw/rtl/assert_macros.svh
// assertion helpers, included by thp_sensor_compensation
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define THP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("thp assertion failed");

// consequent checked in the cycle after the antecedent
`define THP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("thp assertion failed");

`endif

// File: hw/rtl/thp_pkg.sv
// ----------------------------------------------------------------------------
// thp_pkg
// shared types and constants of the sensor compensation pipeline
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int unsigned DivW = 64;

  localparam int unsigned RawTW = 20;
  localparam int unsigned RawPW = 20;
  localparam int unsigned RawHW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [31:0] HumClamp = 32'd419430400;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP   = 3'd0,
    CFG_PRES_A = 3'd1,
    CFG_PRES_B = 3'd2,
    CFG_PRES_C = 3'd3,
    CFG_HUM    = 3'd4
  } cfg_idx_e;

  // side data that rides through the divider with each sample
  typedef struct packed {
    logic [31:0] tmc;
    logic [31:0] hx2;
    logic [31:0] hss;
    logic        zero;
    logic        neg;
  } thp_tag_t;

endpackage

// File: hw/rtl/thp_if.sv
// ----------------------------------------------------------------------------
// thp channels
// valid/ready channels for samples, results and calibration writes
// ----------------------------------------------------------------------------
interface thp_in_if;
  logic                          valid;
  logic                          ready;
  logic [thp_pkg::RawTW-1:0]     raw_temperature;
  logic [thp_pkg::RawPW-1:0]     raw_pressure;
  logic [thp_pkg::RawHW-1:0]     raw_humidity;
  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface thp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_milli_c;
  logic [23:0]        pressure_pa;
  logic [16:0]        humidity_milli_pct;
  modport source (output valid, temperature_milli_c, pressure_pa, humidity_milli_pct,
                  input ready);
  modport sink (input valid, temperature_milli_c, pressure_pa, humidity_milli_pct,
                output ready);
endinterface

interface thp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [thp_pkg::CfgIdxW-1:0]     index;
  logic [thp_pkg::CfgDataW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/thp_div.sv
// ----------------------------------------------------------------------------
// thp_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module thp_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [thp_pkg::DivW-1:0]        dividend_i,
  input  logic [thp_pkg::DivW-1:0]        divisor_i,
  input  thp_pkg::thp_tag_t               tag_i,
  output logic                            valid_o,
  output logic [thp_pkg::DivW-1:0]        quotient_o,
  output thp_pkg::thp_tag_t               tag_o
);

  localparam int unsigned W = thp_pkg::DivW;

  logic                vld_q [W];
  logic [W-1:0]        rem_q [W];
  logic [W-1:0]        aq_q  [W];
  logic [W-1:0]        dvs_q [W];
  thp_pkg::thp_tag_t   tag_q [W];

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic              vld_s;
    logic [W-1:0]      rem_s;
    logic [W-1:0]      aq_s;
    logic [W-1:0]      dvs_s;
    thp_pkg::thp_tag_t tag_s;
    logic [W:0]        trial;
    logic [W:0]        diff;

    if (g == 0) begin : g_first
      assign vld_s = valid_i;
      assign rem_s = '0;
      assign aq_s  = dividend_i;
      assign dvs_s = divisor_i;
      assign tag_s = tag_i;
    end else begin : g_next
      assign vld_s = vld_q[g-1];
      assign rem_s = rem_q[g-1];
      assign aq_s  = aq_q[g-1];
      assign dvs_s = dvs_q[g-1];
      assign tag_s = tag_q[g-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_s, aq_s[W-1]};
    assign diff  = trial - {1'b0, dvs_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        aq_q[g]  <= {aq_s[W-2:0], ~diff[W]};
        dvs_q[g] <= dvs_s;
        tag_q[g] <= tag_s;
      end
    end
  end

  assign valid_o    = vld_q[W-1];
  assign quotient_o = aq_q[W-1];
  assign tag_o      = tag_q[W-1];

endmodule

// File: hw/rtl/thp_sensor_compensation.sv
// ----------------------------------------------------------------------------
// thp_sensor_compensation
// integer compensation of raw temperature, pressure and humidity samples
// ----------------------------------------------------------------------------
// usage:
//   cfg_i takes calibration writes (index 0..4, others ignored); it is always
//   ready and should only be written while no sample is in flight.
//   in_i takes one set of raw readings per transfer, out_o returns one set of
//   compensated values per transfer, in order.
//   the pipeline has 77 register stages: nine stages of temperature, humidity and
//   pressure arithmetic, a 64-stage unsigned divider (one quotient bit per
//   stage), and four stages of pressure and humidity post-processing.
//   throughput is one sample per cycle while the output is taken.
//   the whole pipeline advances together; when the receiver holds ready low
//   with a result waiting, every stage and in_i.ready freeze, nothing is lost.
//   reset clears all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
module thp_sensor_compensation (
  input  logic clk_i,
  input  logic rst_ni,
  thp_cfg_if.sink   cfg_i,
  thp_in_if.sink    in_i,
  thp_out_if.source out_o
);

  // calibration registers
  logic [47:0] cal_t_q;
  logic [63:0] cal_pa_q;
  logic [63:0] cal_pb_q;
  logic [15:0] cal_pc_q;
  logic [63:0] cal_h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pa_q <= '0;
      cal_pb_q <= '0;
      cal_pc_q <= '0;
      cal_h_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        thp_pkg::CFG_TEMP:   cal_t_q  <= cfg_i.data[47:0];
        thp_pkg::CFG_PRES_A: cal_pa_q <= cfg_i.data;
        thp_pkg::CFG_PRES_B: cal_pb_q <= cfg_i.data;
        thp_pkg::CFG_PRES_C: cal_pc_q <= cfg_i.data[15:0];
        thp_pkg::CFG_HUM:    cal_h_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic        [7:0]  h1, h3;
  logic signed [15:0] h2;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = cal_t_q[15:0];
  assign t2 = cal_t_q[31:16];
  assign t3 = cal_t_q[47:32];
  assign p1 = cal_pa_q[15:0];
  assign p2 = cal_pa_q[31:16];
  assign p3 = cal_pa_q[47:32];
  assign p4 = cal_pa_q[63:48];
  assign p5 = cal_pb_q[15:0];
  assign p6 = cal_pb_q[31:16];
  assign p7 = cal_pb_q[47:32];
  assign p8 = cal_pb_q[63:48];
  assign p9 = cal_pc_q;
  assign h1 = cal_h_q[7:0];
  assign h2 = cal_h_q[23:8];
  assign h3 = cal_h_q[31:24];
  assign h4 = cal_h_q[43:32];
  assign h5 = cal_h_q[55:44];
  assign h6 = cal_h_q[63:56];

  // global advance: the whole pipe moves unless a result is held
  logic out_vld_q;
  logic en;
  logic in_fire;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;
  assign in_fire    = in_i.valid && en;

  logic [8:0] s_vld_q;
  logic [2:0] p_vld_q;
  logic       div_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q   <= '0;
      p_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s_vld_q   <= {s_vld_q[7:0], in_fire};
      p_vld_q   <= {p_vld_q[1:0], div_vld};
      out_vld_q <= p_vld_q[2];
    end
  end

  // ---------------- stage 1: input register
  logic [19:0] s1_adc_t_q, s1_adc_p_q;
  logic [15:0] s1_adc_h_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_adc_t_q <= in_i.raw_temperature;
      s1_adc_p_q <= in_i.raw_pressure;
      s1_adc_h_q <= in_i.raw_humidity;
    end
  end

  // ---------------- stage 2: temperature products
  logic signed [17:0] t_da;
  logic signed [16:0] t_d;
  logic signed [33:0] t_a_full, t_dd_full;
  logic signed [31:0] s2_ta_q, s2_tdd_q;
  logic [19:0]        s2_adc_p_q;
  logic [15:0]        s2_adc_h_q;

  assign t_da      = $signed({1'b0, s1_adc_t_q[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign t_d       = $signed({1'b0, s1_adc_t_q[19:4]}) - $signed({1'b0, t1});
  assign t_a_full  = t_da * t2;
  assign t_dd_full = t_d * t_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ta_q    <= t_a_full[31:0];
      s2_tdd_q   <= t_dd_full[31:0];
      s2_adc_p_q <= s1_adc_p_q;
      s2_adc_h_q <= s1_adc_h_q;
    end
  end

  // ---------------- stage 3
  logic signed [31:0] t_dd_sh;
  logic signed [47:0] t_x_full;
  logic signed [31:0] s3_tv1_q, s3_tx_q;
  logic [19:0]        s3_adc_p_q;
  logic [15:0]        s3_adc_h_q;

  assign t_dd_sh  = s2_tdd_q >>> 12;
  assign t_x_full = t_dd_sh * t3;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_tv1_q   <= s2_ta_q >>> 11;
      s3_tx_q    <= t_x_full[31:0];
      s3_adc_p_q <= s2_adc_p_q;
      s3_adc_h_q <= s2_adc_h_q;
    end
  end

  // ---------------- stage 4: fine temperature
  logic signed [31:0] s4_tfine_q;
  logic [19:0]        s4_adc_p_q;
  logic [15:0]        s4_adc_h_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_tfine_q <= s3_tv1_q + (s3_tx_q >>> 14);
      s4_adc_p_q <= s3_adc_p_q;
      s4_adc_h_q <= s3_adc_h_q;
    end
  end

  // ---------------- stage 5: temperature result, offsets
  logic signed [31:0] t_c, t_cent;
  logic signed [31:0] s5_tmc_q, s5_hx_q;
  logic signed [32:0] s5_w1_q;
  logic [19:0]        s5_adc_p_q;
  logic [15:0]        s5_adc_h_q;

  assign t_c    = s4_tfine_q * 32'sd5 + 32'sd128;
  assign t_cent = t_c >>> 8;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_tmc_q   <= t_cent * 32'sd10;
      s5_hx_q    <= s4_tfine_q - 32'sd76800;
      s5_w1_q    <= $signed({s4_tfine_q[31], s4_tfine_q}) - 33'sd128000;
      s5_adc_p_q <= s4_adc_p_q;
      s5_adc_h_q <= s4_adc_h_q;
    end
  end

  // ---------------- stage 6
  logic signed [65:0] p_sq_full;
  logic signed [48:0] p_w1p5, p_w1p2;
  logic signed [43:0] h_h5x;
  logic signed [39:0] h_xh6;
  logic signed [40:0] h_xh3;
  logic signed [63:0] s6_sq_q;
  logic signed [48:0] s6_w1p5_q, s6_w1p2_q;
  logic signed [31:0] s6_ha_pre_q, s6_xh6_q, s6_xh3_q, s6_tmc_q;
  logic [19:0]        s6_adc_p_q;

  assign p_sq_full = s5_w1_q * s5_w1_q;
  assign p_w1p5    = s5_w1_q * p5;
  assign p_w1p2    = s5_w1_q * p2;
  assign h_h5x     = h5 * s5_hx_q;
  assign h_xh6     = s5_hx_q * h6;
  assign h_xh3     = s5_hx_q * $signed({1'b0, h3});

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_sq_q     <= p_sq_full[63:0];
      s6_w1p5_q   <= p_w1p5;
      s6_w1p2_q   <= p_w1p2;
      s6_ha_pre_q <= $signed({2'b00, s5_adc_h_q, 14'd0}) - $signed({h4, 20'd0})
                     - h_h5x[31:0] + 32'sd16384;
      s6_xh6_q    <= h_xh6[31:0];
      s6_xh3_q    <= h_xh3[31:0];
      s6_tmc_q    <= s5_tmc_q;
      s6_adc_p_q  <= s5_adc_p_q;
    end
  end

  // ---------------- stage 7
  logic signed [79:0] p_sq6, p_sq3;
  logic signed [31:0] h_xh6_sh, h_xh3_sh;
  logic signed [63:0] h_hb0_full;
  logic signed [63:0] s7_w2_q, s7_var1a_q;
  logic signed [48:0] s7_w1p2_q;
  logic signed [31:0] s7_ha_q, s7_hb0_q, s7_tmc_q;
  logic [19:0]        s7_adc_p_q;

  assign p_sq6      = s6_sq_q * p6;
  assign p_sq3      = s6_sq_q * p3;
  assign h_xh6_sh   = s6_xh6_q >>> 10;
  assign h_xh3_sh   = (s6_xh3_q >>> 11) + 32'sd32768;
  assign h_hb0_full = h_xh6_sh * h_xh3_sh;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_w2_q    <= p_sq6[63:0] + $signed({s6_w1p5_q[46:0], 17'd0})
                    + $signed({{13{p4[15]}}, p4, 35'd0});
      s7_var1a_q <= p_sq3[63:0];
      s7_w1p2_q  <= s6_w1p2_q;
      s7_ha_q    <= s6_ha_pre_q >>> 15;
      s7_hb0_q   <= h_hb0_full[31:0];
      s7_tmc_q   <= s6_tmc_q;
      s7_adc_p_q <= s6_adc_p_q;
    end
  end

  // ---------------- stage 8
  logic [20:0]        p_pdiff;
  logic signed [31:0] h_hb1;
  logic signed [47:0] h_hb2_full;
  logic signed [63:0] s8_v1_q, s8_nsh_q;
  logic signed [31:0] s8_ha_q, s8_hb2_q, s8_tmc_q;

  assign p_pdiff    = 21'd1048576 - {1'b0, s7_adc_p_q};
  assign h_hb1      = (s7_hb0_q >>> 10) + 32'sd2097152;
  assign h_hb2_full = h_hb1 * h2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_v1_q  <= (s7_var1a_q >>> 8) + $signed({{3{s7_w1p2_q[48]}}, s7_w1p2_q, 12'd0});
      s8_nsh_q <= $signed({12'd0, p_pdiff, 31'd0}) - s7_w2_q;
      s8_ha_q  <= s7_ha_q;
      s8_hb2_q <= h_hb2_full[31:0] + 32'sd8192;
      s8_tmc_q <= s7_tmc_q;
    end
  end

  // ---------------- stage 9
  logic signed [80:0] p_v1b_full;
  logic signed [76:0] p_num_full;
  logic signed [31:0] h_hb;
  logic signed [63:0] h_hx2_full;
  logic signed [63:0] s9_v1b_q, s9_num_q;
  logic signed [31:0] s9_hx2_q, s9_tmc_q;

  assign p_v1b_full = (64'sh0000_8000_0000_0000 + s8_v1_q) * $signed({1'b0, p1});
  assign p_num_full = s8_nsh_q * 13'sd3125;
  assign h_hb       = s8_hb2_q >>> 14;
  assign h_hx2_full = s8_ha_q * h_hb;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_v1b_q <= p_v1b_full[63:0];
      s9_num_q <= p_num_full[63:0];
      s9_hx2_q <= h_hx2_full[31:0];
      s9_tmc_q <= s8_tmc_q;
    end
  end

  // ---------------- divider entry: magnitudes and signs
  logic signed [63:0] p_dv;
  logic [63:0]        p_ua, p_ub;
  logic signed [31:0] h_hs;
  logic signed [63:0] h_hss_full;
  thp_pkg::thp_tag_t  div_tag_in, div_tag_out;
  logic [63:0]        div_q;

  assign p_dv       = s9_v1b_q >>> 33;
  assign p_ua       = s9_num_q[63] ? 64'd0 - s9_num_q : s9_num_q;
  assign p_ub       = p_dv[63] ? 64'd0 - p_dv : p_dv;
  assign h_hs       = s9_hx2_q >>> 15;
  assign h_hss_full = h_hs * h_hs;

  always_comb begin
    div_tag_in.tmc  = s9_tmc_q;
    div_tag_in.hx2  = s9_hx2_q;
    div_tag_in.hss  = h_hss_full[31:0];
    div_tag_in.zero = (p_dv == 64'sd0);
    div_tag_in.neg  = s9_num_q[63] ^ p_dv[63];
  end

  thp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_vld_q[8]),
    .dividend_i (p_ua),
    .divisor_i  (p_ub),
    .tag_i      (div_tag_in),
    .valid_o    (div_vld),
    .quotient_o (div_q),
    .tag_o      (div_tag_out)
  );

  // ---------------- post 1: signed quotient, p9/p8 terms, humidity term
  logic signed [63:0] q_p, q_ps;
  logic signed [79:0] q_t_full, q_w2b_full;
  logic signed [40:0] h_hy_full;
  logic signed [63:0] r1_p_q, r1_ps_q, r1_t_q, r1_w2b_q;
  logic signed [31:0] r1_hy_q;
  thp_pkg::thp_tag_t  r1_tag_q;

  assign q_p        = div_tag_out.neg ? 64'd0 - div_q : div_q;
  assign q_ps       = q_p >>> 13;
  assign q_t_full   = p9 * q_ps;
  assign q_w2b_full = p8 * q_p;
  assign h_hy_full  = ($signed(div_tag_out.hss) >>> 7) * $signed({1'b0, h1});

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_p_q   <= q_p;
      r1_ps_q  <= q_ps;
      r1_t_q   <= q_t_full[63:0];
      r1_w2b_q <= q_w2b_full[63:0];
      r1_hy_q  <= h_hy_full[31:0];
      r1_tag_q <= div_tag_out;
    end
  end

  // ---------------- post 2: partial products of t*ps, humidity finish
  logic [63:0]        m_ll, m_lh, m_hl;
  logic [31:0]        m_mid;
  logic signed [31:0] h_xr;
  logic [31:0]        h_xc;
  logic [16:0]        h_hq;
  logic [26:0]        h_hum_full;
  logic [63:0]        r2_ll_q;
  logic [31:0]        r2_mid_q;
  logic signed [63:0] r2_p_q, r2_w2b_q;
  logic [16:0]        r2_hum_q;
  logic [31:0]        r2_tmc_q;
  logic               r2_zero_q;

  assign m_ll  = r1_t_q[31:0] * r1_ps_q[31:0];
  assign m_lh  = r1_t_q[31:0] * r1_ps_q[63:32];
  assign m_hl  = r1_t_q[63:32] * r1_ps_q[31:0];
  assign m_mid = m_lh[31:0] + m_hl[31:0];

  // humidity clamp to 0 .. HumClamp before the final shift
  assign h_xr = $signed(r1_tag_q.hx2) - (r1_hy_q >>> 4);
  always_comb begin
    if (h_xr[31]) begin
      h_xc = '0;
    end else if (h_xr > thp_pkg::HumClamp) begin
      h_xc = thp_pkg::HumClamp;
    end else begin
      h_xc = h_xr;
    end
  end
  assign h_hq       = h_xc[28:12];
  assign h_hum_full = {10'd0, h_hq} * 27'd1000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_ll_q   <= m_ll;
      r2_mid_q  <= m_mid;
      r2_p_q    <= r1_p_q;
      r2_w2b_q  <= r1_w2b_q;
      r2_hum_q  <= h_hum_full[26:10];
      r2_tmc_q  <= r1_tag_q.tmc;
      r2_zero_q <= r1_tag_q.zero;
    end
  end

  // ---------------- post 3: pressure sum
  logic signed [63:0] m_prod;
  logic signed [63:0] r3_psum_q;
  logic [16:0]        r3_hum_q;
  logic [31:0]        r3_tmc_q;
  logic               r3_zero_q;

  assign m_prod = r2_ll_q + {r2_mid_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      r3_psum_q <= r2_p_q + (m_prod >>> 25) + (r2_w2b_q >>> 19);
      r3_hum_q  <= r2_hum_q;
      r3_tmc_q  <= r2_tmc_q;
      r3_zero_q <= r2_zero_q;
    end
  end

  // ---------------- output register
  logic [31:0] f_pres;
  logic [23:0] out_pres_q;
  logic [16:0] out_hum_q;
  logic [31:0] out_tmc_q;

  assign f_pres = r3_psum_q[39:8] + {{12{p7[15]}}, p7, 4'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pres_q <= r3_zero_q ? 24'd0 : f_pres[31:8];
      out_hum_q  <= r3_hum_q;
      out_tmc_q  <= r3_tmc_q;
    end
  end

  assign out_o.valid               = out_vld_q;
  assign out_o.temperature_milli_c = out_tmc_q;
  assign out_o.pressure_pa         = out_pres_q;
  assign out_o.humidity_milli_pct  = out_hum_q;

`include "assert_macros.svh"

  `THP_ASSERT(a_stall_blocks_input, (out_o.valid && !out_o.ready) |-> !in_i.ready)
  `THP_ASSERT(a_hum_range, out_o.valid |-> (out_o.humidity_milli_pct <= 17'd100000))
  `THP_ASSERT_NEXT(a_stall_holds_pipe, (out_o.valid && !out_o.ready), $stable(s_vld_q))

endmodule
